>>> rtl/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned CP_W   = 16;
  localparam int unsigned MAX_RES = 3;

  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

  localparam logic [CP_W-1:0] CP_1B_MAX = 16'h007F;
  localparam logic [CP_W-1:0] CP_2B_MAX = 16'h07FF;

  localparam logic [BYTE_W-1:0] UTF_LEAD2 = 8'hC0;
  localparam logic [BYTE_W-1:0] UTF_LEAD3 = 8'hE0;
  localparam logic [BYTE_W-1:0] UTF_CONT  = 8'h80;

  typedef enum logic [KIND_W-1:0] {
    K_DATA = 2'd0,
    K_DONE = 2'd1,
    K_ERR  = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    E_NONE      = 3'd0,
    E_BAD_DELIM = 3'd1,
    E_CTRL      = 3'd2,
    E_BAD_ESC   = 3'd3,
    E_BAD_HEX   = 3'd4,
    E_EARLY_END = 3'd5
  } err_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    kind_t             kind;
    err_t              code;
    logic              last;
  } res_t;

  function automatic res_t mk_res(logic [BYTE_W-1:0] data, kind_t kind, err_t code);
    res_t r;
    r.data = data;
    r.kind = kind;
    r.code = code;
    r.last = 1'b0;
    return r;
  endfunction

  // Bit 4 is the valid flag, bits 3:0 the digit value.
  function automatic logic [4:0] hex_value(logic [BYTE_W-1:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // Bit 8 is the valid flag, bits 7:0 the decoded byte.
  function automatic logic [8:0] simple_escape(logic [BYTE_W-1:0] c);
    logic [8:0] v;
    case (c)
      8'h22:   v = {1'b1, 8'h22};
      8'h27:   v = {1'b1, 8'h27};
      8'h5C:   v = {1'b1, 8'h5C};
      8'h2F:   v = {1'b1, 8'h2F};
      8'h62:   v = {1'b1, 8'h08};
      8'h66:   v = {1'b1, 8'h0C};
      8'h6E:   v = {1'b1, 8'h0A};
      8'h72:   v = {1'b1, 8'h0D};
      8'h74:   v = {1'b1, 8'h09};
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/jsu_if.sv
`default_nettype none
interface jsu_in_if;
  logic                       valid;
  logic                       ready;
  logic [jsu_pkg::BYTE_W-1:0] in_byte;
  logic                       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic                       valid;
  logic                       ready;
  logic [jsu_pkg::BYTE_W-1:0] out_byte;
  logic [jsu_pkg::KIND_W-1:0] kind;
  logic [jsu_pkg::ERR_W-1:0]  error_code;
  logic                       last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input error_code,
                input last, output ready);
endinterface
`default_nettype wire

>>> rtl/json_string_unescape_utf8_top.sv
`default_nettype none
// The first result of an input beat is presented in the cycle after the beat is accepted.
// Throughput: one input beat per cycle while out_s.ready stays high and each beat yields at
// most one result; a closing \u escape yields 1 to 3 results and holds the input until its
// last result is being taken. The three-entry result register drains one result per
// accepted output beat. Reset (rst_n low, synchronous) returns to idle, empties the result
// register and clears allow_r, the single-quote enable.
module json_string_unescape_utf8_top (
  input  wire           clk,
  input  wire           rst_n,
  jsu_in_if.sink        in_s,
  jsu_out_if.source     out_s,
  input  wire           cfg_we,
  input  wire           cfg_wdata
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TEXT = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic                        single_r, single_nxt;
  logic [1:0]                  hex_r, hex_nxt;
  logic [jsu_pkg::CP_W-1:0]    acc_r, acc_nxt;
  logic                        allow_r;
  logic [1:0]                  cnt_r;
  jsu_pkg::res_t               res_r [jsu_pkg::MAX_RES];
  jsu_pkg::res_t               res_nxt [jsu_pkg::MAX_RES];
  logic [1:0]                  n_nxt;

  logic                        push;
  logic                        pop;
  logic [jsu_pkg::BYTE_W-1:0]  b;
  logic [jsu_pkg::BYTE_W-1:0]  close_q;
  logic [4:0]                  hv;
  logic [8:0]                  ev;
  logic [jsu_pkg::CP_W-1:0]    cp;

  assign pop        = (cnt_r != 2'd0) && out_s.ready;
  assign in_s.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_s.ready);
  assign push       = in_s.valid && in_s.ready;
  assign b          = in_s.in_byte;
  assign close_q    = single_r ? jsu_pkg::CH_SQUOTE : jsu_pkg::CH_DQUOTE;
  assign hv         = jsu_pkg::hex_value(b);
  assign ev         = jsu_pkg::simple_escape(b);
  assign cp         = {acc_r[jsu_pkg::CP_W-5:0], hv[3:0]};

  assign out_s.valid      = (cnt_r != 2'd0);
  assign out_s.out_byte   = res_r[0].data;
  assign out_s.kind       = res_r[0].kind;
  assign out_s.error_code = res_r[0].code;
  assign out_s.last       = res_r[0].last;

  always_comb begin
    phase_nxt  = phase_r;
    single_nxt = single_r;
    hex_nxt    = hex_r;
    acc_nxt    = acc_r;
    n_nxt      = 2'd0;
    for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
      res_nxt[i] = jsu_pkg::mk_res('0, jsu_pkg::K_DATA, jsu_pkg::E_NONE);
    end
    case (phase_r)
      PH_IDLE: begin
        if (!in_s.end_of_input && b == jsu_pkg::CH_DQUOTE) begin
          single_nxt = 1'b0;
          phase_nxt  = PH_TEXT;
        end else if (!in_s.end_of_input && b == jsu_pkg::CH_SQUOTE && allow_r) begin
          single_nxt = 1'b1;
          phase_nxt  = PH_TEXT;
        end else begin
          res_nxt[0] = jsu_pkg::mk_res('0, jsu_pkg::K_ERR, jsu_pkg::E_BAD_DELIM);
          n_nxt      = 2'd1;
        end
      end
      PH_TEXT: begin
        if (in_s.end_of_input) begin
          res_nxt[0] = jsu_pkg::mk_res('0, jsu_pkg::K_ERR, jsu_pkg::E_EARLY_END);
          n_nxt      = 2'd1;
          phase_nxt  = PH_IDLE;
        end else if (b == close_q) begin
          res_nxt[0] = jsu_pkg::mk_res('0, jsu_pkg::K_DONE, jsu_pkg::E_NONE);
          n_nxt      = 2'd1;
          phase_nxt  = PH_IDLE;
        end else if (b == jsu_pkg::CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else if (b < jsu_pkg::CH_SPACE) begin
          res_nxt[0] = jsu_pkg::mk_res('0, jsu_pkg::K_ERR, jsu_pkg::E_CTRL);
          n_nxt      = 2'd1;
          phase_nxt  = PH_IDLE;
        end else begin
          res_nxt[0] = jsu_pkg::mk_res(b, jsu_pkg::K_DATA, jsu_pkg::E_NONE);
          n_nxt      = 2'd1;
        end
      end
      PH_ESC: begin
        if (in_s.end_of_input) begin
          res_nxt[0] = jsu_pkg::mk_res('0, jsu_pkg::K_ERR, jsu_pkg::E_EARLY_END);
          n_nxt      = 2'd1;
          phase_nxt  = PH_IDLE;
        end else if (b == jsu_pkg::CH_U) begin
          phase_nxt = PH_HEX;
          hex_nxt   = 2'd0;
          acc_nxt   = '0;
        end else if (!ev[8]) begin
          res_nxt[0] = jsu_pkg::mk_res('0, jsu_pkg::K_ERR, jsu_pkg::E_BAD_ESC);
          n_nxt      = 2'd1;
          phase_nxt  = PH_IDLE;
        end else begin
          res_nxt[0] = jsu_pkg::mk_res(ev[7:0], jsu_pkg::K_DATA, jsu_pkg::E_NONE);
          n_nxt      = 2'd1;
          phase_nxt  = PH_TEXT;
        end
      end
      PH_HEX: begin
        if (in_s.end_of_input || !hv[4]) begin
          res_nxt[0] = jsu_pkg::mk_res('0, jsu_pkg::K_ERR,
                         in_s.end_of_input ? jsu_pkg::E_EARLY_END : jsu_pkg::E_BAD_HEX);
          n_nxt      = 2'd1;
          phase_nxt  = PH_IDLE;
          hex_nxt    = 2'd0;
        end else begin
          acc_nxt = cp;
          if (hex_r == 2'd3) begin
            hex_nxt   = 2'd0;
            phase_nxt = PH_TEXT;
            // The code point is encoded alone; surrogates are not paired.
            if (cp <= jsu_pkg::CP_1B_MAX) begin
              res_nxt[0] = jsu_pkg::mk_res(cp[7:0], jsu_pkg::K_DATA, jsu_pkg::E_NONE);
              n_nxt      = 2'd1;
            end else if (cp <= jsu_pkg::CP_2B_MAX) begin
              res_nxt[0] = jsu_pkg::mk_res(jsu_pkg::UTF_LEAD2 | {3'd0, cp[10:6]},
                                           jsu_pkg::K_DATA, jsu_pkg::E_NONE);
              res_nxt[1] = jsu_pkg::mk_res(jsu_pkg::UTF_CONT | {2'd0, cp[5:0]},
                                           jsu_pkg::K_DATA, jsu_pkg::E_NONE);
              n_nxt      = 2'd2;
            end else begin
              res_nxt[0] = jsu_pkg::mk_res(jsu_pkg::UTF_LEAD3 | {4'd0, cp[15:12]},
                                           jsu_pkg::K_DATA, jsu_pkg::E_NONE);
              res_nxt[1] = jsu_pkg::mk_res(jsu_pkg::UTF_CONT | {2'd0, cp[11:6]},
                                           jsu_pkg::K_DATA, jsu_pkg::E_NONE);
              res_nxt[2] = jsu_pkg::mk_res(jsu_pkg::UTF_CONT | {2'd0, cp[5:0]},
                                           jsu_pkg::K_DATA, jsu_pkg::E_NONE);
              n_nxt      = 2'd3;
            end
          end else begin
            hex_nxt = hex_r + 2'd1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    case (n_nxt)
      2'd1:    res_nxt[0].last = 1'b1;
      2'd2:    res_nxt[1].last = 1'b1;
      2'd3:    res_nxt[2].last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      single_r <= 1'b0;
      hex_r    <= 2'd0;
      acc_r    <= '0;
      allow_r  <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_we) begin
        allow_r <= cfg_wdata;
      end
      if (push) begin
        phase_r  <= phase_nxt;
        single_r <= single_nxt;
        hex_r    <= hex_nxt;
        acc_r    <= acc_nxt;
        cnt_r    <= n_nxt;
      end else if (pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // A new beat only loads the result register once the old results are gone.
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end else if (pop) begin
      for (int i = 0; i < jsu_pkg::MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> (out_s.last == (cnt_r == 2'd1)))
    else $error("last flag does not match the final buffered result");

  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (push && n_nxt != 2'd0 && res_nxt[0].kind == jsu_pkg::K_ERR) |=> (phase_r == PH_IDLE))
    else $error("error result did not return the block to idle");

  a_hex_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (hex_r != 2'd0) |-> (phase_r == PH_HEX))
    else $error("hex digit count is live outside a unicode escape");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && out_s.kind == jsu_pkg::K_ERR) |->
      (out_s.error_code != jsu_pkg::E_NONE && out_s.out_byte == '0 && out_s.last))
    else $error("malformed error result");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int HOLD_CYCLES = 48;

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_TEXT = 2'd1,
    SCAN_ESC  = 2'd2,
    SCAN_HEX  = 2'd3
  } scan_t;

  typedef struct {
    logic [7:0]    b;
    logic          eoi;
    logic          pinned;
    jsu_pkg::res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Decoder state mirrored by the testbench.
  scan_t       scan_st   = SCAN_IDLE;
  logic        in_single = 1'b0;
  logic [1:0]  hex_count = 2'd0;
  logic [15:0] cp_acc    = 16'd0;
  logic        allow_sq  = 1'b0;

  jsu_pkg::res_t decoded[$];
  jsu_pkg::res_t pending_results[$];
  stim_row_t     directed_rows[$];

  int   beats_sent = 0;
  int   n_fail     = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_req   = 1'b0;

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (lc >= 8'h61 && lc <= 8'h66) return {1'b1, 4'(lc - 8'h57)};
    return 5'd0;
  endfunction

  function automatic logic [8:0] unescaped(logic [7:0] c);
    case (c)
      8'h22, 8'h27, 8'h5C, 8'h2F: return {1'b1, c};
      8'h62:   return {1'b1, 8'h08};
      8'h66:   return {1'b1, 8'h0C};
      8'h6E:   return {1'b1, 8'h0A};
      8'h72:   return {1'b1, 8'h0D};
      8'h74:   return {1'b1, 8'h09};
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void emit(logic [7:0] d, jsu_pkg::kind_t k, jsu_pkg::err_t c);
    jsu_pkg::res_t r;
    r.data = d;
    r.kind = k;
    r.code = c;
    r.last = 1'b0;
    decoded.insert(decoded.size(), r);
  endfunction

  function automatic void fault(jsu_pkg::err_t c);
    scan_st = SCAN_IDLE;
    emit(8'h00, jsu_pkg::K_ERR, c);
  endfunction

  // Advances the mirrored decoder by one input beat; results land in decoded.
  function automatic void unescape_step(logic [7:0] b, logic eoi);
    logic [4:0] nib;
    logic [8:0] esc;
    logic [7:0] close_ch;
    decoded.delete();
    nib = nibble_of(b);
    esc = unescaped(b);
    close_ch = in_single ? jsu_pkg::CH_SQUOTE : jsu_pkg::CH_DQUOTE;
    case (scan_st)
      SCAN_IDLE: begin
        if (eoi) fault(jsu_pkg::E_BAD_DELIM);
        else if (b == jsu_pkg::CH_DQUOTE) begin
          in_single = 1'b0;
          scan_st = SCAN_TEXT;
        end else if (b == jsu_pkg::CH_SQUOTE && allow_sq) begin
          in_single = 1'b1;
          scan_st = SCAN_TEXT;
        end else fault(jsu_pkg::E_BAD_DELIM);
      end
      SCAN_TEXT: begin
        if (eoi) fault(jsu_pkg::E_EARLY_END);
        else if (b == close_ch) begin
          scan_st = SCAN_IDLE;
          emit(8'h00, jsu_pkg::K_DONE, jsu_pkg::E_NONE);
        end else if (b == jsu_pkg::CH_BSLASH) scan_st = SCAN_ESC;
        else if (b < jsu_pkg::CH_SPACE) fault(jsu_pkg::E_CTRL);
        else emit(b, jsu_pkg::K_DATA, jsu_pkg::E_NONE);
      end
      SCAN_ESC: begin
        if (eoi) fault(jsu_pkg::E_EARLY_END);
        else if (b == jsu_pkg::CH_U) begin
          scan_st = SCAN_HEX;
          hex_count = 2'd0;
          cp_acc = 16'd0;
        end else if (!esc[8]) fault(jsu_pkg::E_BAD_ESC);
        else begin
          scan_st = SCAN_TEXT;
          emit(esc[7:0], jsu_pkg::K_DATA, jsu_pkg::E_NONE);
        end
      end
      SCAN_HEX: begin
        if (eoi) fault(jsu_pkg::E_EARLY_END);
        else if (!nib[4]) fault(jsu_pkg::E_BAD_HEX);
        else begin
          cp_acc = {cp_acc[11:0], nib[3:0]};
          if (hex_count == 2'd3) begin
            hex_count = 2'd0;
            scan_st = SCAN_TEXT;
            // Each code point is encoded on its own, surrogates included.
            if (cp_acc <= jsu_pkg::CP_1B_MAX) begin
              emit(cp_acc[7:0], jsu_pkg::K_DATA, jsu_pkg::E_NONE);
            end else if (cp_acc <= jsu_pkg::CP_2B_MAX) begin
              emit(jsu_pkg::UTF_LEAD2 | {3'b0, cp_acc[10:6]}, jsu_pkg::K_DATA,
                   jsu_pkg::E_NONE);
              emit(jsu_pkg::UTF_CONT | {2'b0, cp_acc[5:0]}, jsu_pkg::K_DATA,
                   jsu_pkg::E_NONE);
            end else begin
              emit(jsu_pkg::UTF_LEAD3 | {4'b0, cp_acc[15:12]}, jsu_pkg::K_DATA,
                   jsu_pkg::E_NONE);
              emit(jsu_pkg::UTF_CONT | {2'b0, cp_acc[11:6]}, jsu_pkg::K_DATA,
                   jsu_pkg::E_NONE);
              emit(jsu_pkg::UTF_CONT | {2'b0, cp_acc[5:0]}, jsu_pkg::K_DATA,
                   jsu_pkg::E_NONE);
            end
          end else begin
            hex_count = hex_count + 2'd1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic stim_row_t beat(logic [7:0] b, logic eoi);
    stim_row_t r;
    r.b = b;
    r.eoi = eoi;
    r.pinned = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t beat_want(logic [7:0] b, logic eoi, logic [7:0] d,
                                          jsu_pkg::kind_t k, jsu_pkg::err_t c);
    stim_row_t r;
    r = beat(b, eoi);
    r.pinned = 1'b1;
    r.want.data = d;
    r.want.kind = k;
    r.want.code = c;
    r.want.last = 1'b1;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(stim_row_t r);
    while (tx_idle_on && $urandom_range(0, 99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= r.b;
    in_ch.end_of_input <= r.eoi;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    unescape_step(r.b, r.eoi);
    if (decoded.size() > 0) decoded[decoded.size() - 1].last = 1'b1;
    if (r.pinned) pending_results.insert(pending_results.size(), r.want);
    else foreach (decoded[i]) pending_results.insert(pending_results.size(), decoded[i]);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Beats that open a string or an escape give no result; let them finish.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    allow_sq = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed strings with random content, some with a fault injected.
  task automatic send_string();
    logic [7:0]  delim;
    logic [7:0]  b;
    logic [8:0]  esc;
    logic [15:0] cp;
    int          n_elem;
    int          fault_at;
    int          pick;
    int          k;
    delim = (allow_sq && $urandom_range(0, 1)) ? jsu_pkg::CH_SQUOTE : jsu_pkg::CH_DQUOTE;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      do b = 8'($urandom); while (b == jsu_pkg::CH_DQUOTE || b == jsu_pkg::CH_SQUOTE);
      send_beat(beat(b, 1'b0));
    end else if (pick < 7) begin
      send_beat(beat(8'($urandom), 1'b1));
    end else if (pick < 10 && !allow_sq) begin
      send_beat(beat(jsu_pkg::CH_SQUOTE, 1'b0));
    end
    send_beat(beat(delim, 1'b0));
    n_elem = $urandom_range(0, 6);
    fault_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n_elem) : -1;
    for (int i = 0; i < n_elem + 1; i++) begin
      if (i == fault_at) begin
        case ($urandom_range(0, 5))
          0: send_beat(beat(8'($urandom_range(0, 8'h1F)), 1'b0));
          1: begin
            send_beat(beat(jsu_pkg::CH_BSLASH, 1'b0));
            do begin
              b = 8'($urandom);
              esc = unescaped(b);
            end while (esc[8] || b == jsu_pkg::CH_U);
            send_beat(beat(b, 1'b0));
          end
          2, 5: begin
            send_beat(beat(jsu_pkg::CH_BSLASH, 1'b0));
            send_beat(beat(jsu_pkg::CH_U, 1'b0));
            k = $urandom_range(0, 3);
            repeat (k) send_beat(beat(hex_char(4'($urandom)), 1'b0));
            do b = 8'($urandom); while (nibble_of(b) >= 5'h10);
            send_beat(beat(b, fault_at[0]));
          end
          3: send_beat(beat(8'($urandom), 1'b1));
          default: begin
            send_beat(beat(jsu_pkg::CH_BSLASH, 1'b0));
            send_beat(beat(8'($urandom), 1'b1));
          end
        endcase
        return;
      end
      if (i == n_elem) break;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        do b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == delim || b == jsu_pkg::CH_BSLASH);
        send_beat(beat(b, 1'b0));
      end else if (pick < 55) begin
        send_beat(beat((delim == jsu_pkg::CH_SQUOTE) ? jsu_pkg::CH_DQUOTE : jsu_pkg::CH_SQUOTE,
                       1'b0));
      end else if (pick < 75) begin
        do begin
          b = 8'($urandom);
          esc = unescaped(b);
        end while (!esc[8]);
        send_beat(beat(jsu_pkg::CH_BSLASH, 1'b0));
        send_beat(beat(b, 1'b0));
      end else begin
        case ($urandom_range(0, 3))
          0: cp = 16'($urandom_range(0, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
          default: cp = 16'($urandom);
        endcase
        send_beat(beat(jsu_pkg::CH_BSLASH, 1'b0));
        send_beat(beat(jsu_pkg::CH_U, 1'b0));
        for (int d = 3; d >= 0; d--) send_beat(beat(hex_char(cp[4*d +: 4]), 1'b0));
      end
    end
    send_beat(beat(delim, 1'b0));
  endtask

  task automatic run_strings(int n_beats);
    int goal;
    goal = beats_sent + n_beats;
    while (beats_sent < goal) send_string();
  endtask

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(0, 99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    jsu_pkg::res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        n_fail++;
        $display("%0t: expected no beat, got byte=%h kind=%0d code=%0d last=%0b", $time,
                 out_ch.out_byte, out_ch.kind, out_ch.error_code, out_ch.last);
      end else begin
        w = pending_results.pop_front();
        if (out_ch.out_byte !== w.data || out_ch.kind !== w.kind ||
            out_ch.error_code !== w.code || out_ch.last !== w.last) begin
          n_fail++;
          $display("%0t: expected byte=%h kind=%0d code=%0d last=%0b,", $time,
                   w.data, w.kind, w.code, w.last,
                   " got byte=%h kind=%0d code=%0d last=%0b", out_ch.out_byte,
                   out_ch.kind, out_ch.error_code, out_ch.last);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("json_string_unescape_utf8_top test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.end_of_input = 1'b0;

    // Reset leaves single quotes disabled.
    add_row(beat_want(8'hA5, 1'b1, 8'h00, jsu_pkg::K_ERR, jsu_pkg::E_BAD_DELIM));
    add_row(beat_want(jsu_pkg::CH_SQUOTE, 1'b0, 8'h00, jsu_pkg::K_ERR, jsu_pkg::E_BAD_DELIM));
    add_row(beat(jsu_pkg::CH_DQUOTE, 1'b0));
    add_row(beat_want(jsu_pkg::CH_SQUOTE, 1'b0, jsu_pkg::CH_SQUOTE, jsu_pkg::K_DATA,
                      jsu_pkg::E_NONE));
    add_row(beat_want(8'hFF, 1'b0, 8'hFF, jsu_pkg::K_DATA, jsu_pkg::E_NONE));
    // A lone high surrogate still goes out as three bytes.
    add_row(beat(jsu_pkg::CH_BSLASH, 1'b0));
    add_row(beat(jsu_pkg::CH_U, 1'b0));
    add_row(beat(8'h64, 1'b0));
    add_row(beat(8'h38, 1'b0));
    add_row(beat(8'h30, 1'b0));
    add_row(beat(8'h30, 1'b0));
    add_row(beat(jsu_pkg::CH_BSLASH, 1'b0));
    add_row(beat(jsu_pkg::CH_U, 1'b0));
    add_row(beat(8'h30, 1'b0));
    add_row(beat(8'h30, 1'b0));
    add_row(beat(8'h30, 1'b0));
    add_row(beat_want(8'h30, 1'b0, 8'h00, jsu_pkg::K_DATA, jsu_pkg::E_NONE));
    add_row(beat_want(jsu_pkg::CH_DQUOTE, 1'b0, 8'h00, jsu_pkg::K_DONE, jsu_pkg::E_NONE));
    add_row(beat(jsu_pkg::CH_DQUOTE, 1'b0));
    add_row(beat_want(8'h1F, 1'b0, 8'h00, jsu_pkg::K_ERR, jsu_pkg::E_CTRL));
    add_row(beat(jsu_pkg::CH_DQUOTE, 1'b0));
    add_row(beat(jsu_pkg::CH_BSLASH, 1'b0));
    add_row(beat_want(8'h7A, 1'b0, 8'h00, jsu_pkg::K_ERR, jsu_pkg::E_BAD_ESC));
    add_row(beat(jsu_pkg::CH_DQUOTE, 1'b0));
    add_row(beat(jsu_pkg::CH_BSLASH, 1'b0));
    add_row(beat(jsu_pkg::CH_U, 1'b0));
    add_row(beat_want(8'h47, 1'b0, 8'h00, jsu_pkg::K_ERR, jsu_pkg::E_BAD_HEX));
    add_row(beat(jsu_pkg::CH_DQUOTE, 1'b0));
    add_row(beat_want(8'h00, 1'b1, 8'h00, jsu_pkg::K_ERR, jsu_pkg::E_EARLY_END));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    settle();

    write_cfg(1'b1);
    run_strings(30);
    settle();

    // A long stretch with both sides running flat out.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_cfg(1'b0);
    run_strings(30);
    settle();

    // The result side stalls long enough for the input to back up.
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_cfg(1'b1);
    hold_req = 1'b1;
    run_strings(30);
    settle();

    write_cfg(1'b0);
    run_strings(30);
    settle();

    repeat (8) @(negedge clk);
    if (n_fail == 0) begin
      $display("json_string_unescape_utf8_top test passed");
    end else begin
      $display("json_string_unescape_utf8_top test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/json_string_unescape_utf8_top.sv
tb/sv/tb.sv
